// ----- rtl/lsms_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lsms_pkg;

    // field widths of the stream words
    localparam int MODE_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    // input mode codes
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SORT       = 3'd3;
    localparam logic [MODE_W-1:0] MODE_EMIT       = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_ELEMENT  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd3;

endpackage

`default_nettype wire

// ----- rtl/lsms_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lsms_ram #(
    parameter int DEPTH = 32,
    parameter int PTR_W = 5
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [PTR_W-1:0]                 i_waddr,
    input  wire logic [lsms_pkg::VALUE_W-1:0]     i_wdata,
    input  wire logic                             i_re,
    input  wire logic [PTR_W-1:0]                 i_raddr,
    output logic      [lsms_pkg::VALUE_W-1:0]     o_rdata
);

    logic [lsms_pkg::VALUE_W-1:0] r_mem [DEPTH];
    logic [lsms_pkg::VALUE_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, hold data between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/lsms_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lsms_ctrl #(
    parameter int DEPTH = 32,
    parameter int CNT_W = 6,
    parameter int PTR_W = 5
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input words
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [lsms_pkg::MODE_W-1:0]       i_mode,
    input  wire logic [lsms_pkg::VALUE_W-1:0]      i_value,
    // result words
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic      [lsms_pkg::VALUE_W-1:0]      o_element,
    output logic      [lsms_pkg::STATUS_W-1:0]     o_status,
    output logic                                   o_last,
    // element store port
    output logic                                   o_we,
    output logic      [PTR_W-1:0]                  o_waddr,
    output logic      [lsms_pkg::VALUE_W-1:0]      o_wdata,
    output logic                                   o_re,
    output logic      [PTR_W-1:0]                  o_raddr,
    input  wire logic [lsms_pkg::VALUE_W-1:0]      i_rdata,
    // fill level
    output logic      [CNT_W-1:0]                  o_count
);

    localparam int SUM_W = CNT_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_KEY_RD,
        ST_KEY_LD,
        ST_CMP,
        ST_PUT,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } t_state;

    t_state                        r_state, n_state;
    logic [CNT_W-1:0]              r_count, n_count;
    logic [PTR_W-1:0]              r_front, n_front;
    logic [CNT_W-1:0]              r_i, n_i;
    logic [CNT_W-1:0]              r_j, n_j;
    logic [lsms_pkg::VALUE_W-1:0]  r_key, n_key;
    logic                          r_out_valid, n_out_valid;
    logic [lsms_pkg::VALUE_W-1:0]  r_element, n_element;
    logic [lsms_pkg::STATUS_W-1:0] r_status, n_status;
    logic                          r_last, n_last;

    logic                          out_free;
    logic                          accept;
    logic                          is_full;
    logic                          is_empty;
    logic [PTR_W-1:0]              front_dec;
    logic                          key_less;

    // ring slot of the element at a list offset below DEPTH
    function automatic logic [PTR_W-1:0] slot(input logic [PTR_W-1:0] front,
                                             input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(front) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && out_free;
    assign accept     = i_in_valid && o_in_ready;
    assign is_full    = (r_count == CNT_W'(DEPTH));
    assign is_empty   = (r_count == '0);
    assign front_dec  = (r_front == '0) ? PTR_W'(DEPTH - 1) : r_front - PTR_W'(1);
    // compare unit: the element ahead is strictly greater than the key
    assign key_less   = $signed(i_rdata) > $signed(r_key);

    // sequence one input word at a time
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_front     = r_front;
        n_i         = r_i;
        n_j         = r_j;
        n_key       = r_key;
        n_out_valid = r_out_valid && !i_out_ready;
        n_element   = r_element;
        n_status    = r_status;
        n_last      = r_last;
        o_we        = 1'b0;
        o_waddr     = '0;
        o_wdata     = '0;
        o_re        = 1'b0;
        o_raddr     = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_mode) inside
                        lsms_pkg::MODE_PUSH_FRONT, lsms_pkg::MODE_PUSH_BACK: begin
                            n_out_valid = 1'b1;
                            n_element   = '0;
                            n_last      = 1'b1;
                            if (is_full) begin
                                n_status = lsms_pkg::STATUS_FULL;
                            end else begin
                                n_status = lsms_pkg::STATUS_INSERTED;
                                o_we     = 1'b1;
                                o_wdata  = i_value;
                                n_count  = r_count + CNT_W'(1);
                                if (i_mode == lsms_pkg::MODE_PUSH_FRONT) begin
                                    o_waddr = front_dec;
                                    n_front = front_dec;
                                end else begin
                                    o_waddr = slot(r_front, r_count);
                                end
                            end
                        end
                        lsms_pkg::MODE_POP_FRONT: begin
                            if (is_empty) begin
                                n_out_valid = 1'b1;
                                n_element   = '0;
                                n_status    = lsms_pkg::STATUS_EMPTY;
                                n_last      = 1'b1;
                            end else begin
                                o_re    = 1'b1;
                                o_raddr = r_front;
                                n_state = ST_POP;
                            end
                        end
                        lsms_pkg::MODE_SORT, lsms_pkg::MODE_EMIT: begin
                            if (is_empty) begin
                                n_out_valid = 1'b1;
                                n_element   = '0;
                                n_status    = lsms_pkg::STATUS_EMPTY;
                                n_last      = 1'b1;
                            end else if (i_mode == lsms_pkg::MODE_SORT &&
                                         r_count != CNT_W'(1)) begin
                                n_i     = CNT_W'(1);
                                n_state = ST_KEY_RD;
                            end else begin
                                n_i     = '0;
                                n_state = ST_EMIT_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_POP: begin
                // hand out the front word and drop it
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_element   = i_rdata;
                    n_status    = lsms_pkg::STATUS_ELEMENT;
                    n_last      = 1'b1;
                    n_front     = slot(r_front, CNT_W'(1));
                    n_count     = r_count - CNT_W'(1);
                    n_state     = ST_IDLE;
                end
            end
            ST_KEY_RD: begin
                o_re    = 1'b1;
                o_raddr = slot(r_front, r_i);
                n_j     = r_i;
                n_state = ST_KEY_LD;
            end
            ST_KEY_LD: begin
                n_key   = i_rdata;
                o_re    = 1'b1;
                o_raddr = slot(r_front, r_j - CNT_W'(1));
                n_state = ST_CMP;
            end
            ST_CMP: begin
                o_we    = 1'b1;
                o_waddr = slot(r_front, r_j);
                if (key_less) begin
                    // shift the greater word up one place
                    o_wdata = i_rdata;
                    n_j     = r_j - CNT_W'(1);
                    if (r_j == CNT_W'(1)) begin
                        n_state = ST_PUT;
                    end else begin
                        o_re    = 1'b1;
                        o_raddr = slot(r_front, r_j - CNT_W'(2));
                    end
                end else begin
                    o_wdata = r_key;
                    n_i     = r_i + CNT_W'(1);
                    if (r_i + CNT_W'(1) == r_count) begin
                        n_i     = '0;
                        n_state = ST_EMIT_RD;
                    end else begin
                        n_state = ST_KEY_RD;
                    end
                end
            end
            ST_PUT: begin
                o_we    = 1'b1;
                o_waddr = slot(r_front, r_j);
                o_wdata = r_key;
                n_i     = r_i + CNT_W'(1);
                if (r_i + CNT_W'(1) == r_count) begin
                    n_i     = '0;
                    n_state = ST_EMIT_RD;
                end else begin
                    n_state = ST_KEY_RD;
                end
            end
            ST_EMIT_RD: begin
                o_re    = 1'b1;
                o_raddr = slot(r_front, r_i);
                n_state = ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_element   = i_rdata;
                    n_status    = lsms_pkg::STATUS_ELEMENT;
                    n_last      = (r_i + CNT_W'(1) == r_count);
                    if (r_i + CNT_W'(1) == r_count) begin
                        n_i     = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_i     = r_i + CNT_W'(1);
                        n_state = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // hold state and the output register
    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_element <= n_element;
        r_status  <= n_status;
        r_last    <= n_last;
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_front     <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_front     <= n_front;
            r_i         <= n_i;
            r_j         <= n_j;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_element   = r_element;
    assign o_status    = r_status;
    assign o_last      = r_last;
    assign o_count     = r_count;

endmodule

`default_nettype wire

// ----- rtl/list_store_with_merge_sort.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to DEPTH signed 32-bit words held in a ring store, driven by a
// stream of command words (tuser = mode, tdata = value). Push front/back answers one
// inserted or full word in the cycle after accept; pop reads the front word through
// the store's read register and answers it once the output register is free; emit
// answers one word per element, last set on the final one; pop, sort or emit on an
// empty list answers a single empty word. Sort runs a stable insertion pass in place
// before emitting. The pop, sort and emit steps share the single read port of the
// element store, and the sort uses one signed comparator. The block takes a new
// command only when idle and its output register is free or being taken; mode codes
// 5 to 7 are taken and ignored.
module list_store_with_merge_sort #(
    parameter int DEPTH = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // command words
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  wire logic [lsms_pkg::VALUE_W-1:0]      i_s_axis_tdata,  // [31:0] value
    input  wire logic [lsms_pkg::MODE_W-1:0]       i_s_axis_tuser,  // [2:0] mode
    // result words
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    output logic      [lsms_pkg::VALUE_W-1:0]      o_m_axis_tdata,  // [31:0] element
    output logic      [lsms_pkg::STATUS_W-1:0]     o_m_axis_tuser,  // [1:0] status
    output logic                                   o_m_axis_tlast
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PTR_W = $clog2(DEPTH);

    logic                         mem_we;
    logic [PTR_W-1:0]             mem_waddr;
    logic [lsms_pkg::VALUE_W-1:0] mem_wdata;
    logic                         mem_re;
    logic [PTR_W-1:0]             mem_raddr;
    logic [lsms_pkg::VALUE_W-1:0] mem_rdata;
    logic [CNT_W-1:0]             count;

    lsms_ctrl #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W),
        .PTR_W (PTR_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_mode      (i_s_axis_tuser),
        .i_value     (i_s_axis_tdata),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_element   (o_m_axis_tdata),
        .o_status    (o_m_axis_tuser),
        .o_last      (o_m_axis_tlast),
        .o_we        (mem_we),
        .o_waddr     (mem_waddr),
        .o_wdata     (mem_wdata),
        .o_re        (mem_re),
        .o_raddr     (mem_raddr),
        .i_rdata     (mem_rdata),
        .o_count     (count)
    );

    lsms_ram #(
        .DEPTH (DEPTH),
        .PTR_W (PTR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    logic s_accept;
    logic push_cmd;

    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign push_cmd = (i_s_axis_tuser == lsms_pkg::MODE_PUSH_FRONT) ||
                      (i_s_axis_tuser == lsms_pkg::MODE_PUSH_BACK);

    // fill level never passes the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= CNT_W'(DEPTH))
        else $error("element count above depth");

    // a push into a full list is refused at once and leaves the count alone
    a_full_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && push_cmd && count == CNT_W'(DEPTH) |=>
        o_m_axis_tvalid && o_m_axis_tlast &&
        o_m_axis_tuser == lsms_pkg::STATUS_FULL && count == $past(count))
        else $error("full push not refused");

    // a push with room grows the list by one
    a_push_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && push_cmd && count != CNT_W'(DEPTH) |=>
        count == $past(count) + CNT_W'(1) &&
        o_m_axis_tuser == lsms_pkg::STATUS_INSERTED)
        else $error("push did not grow the list");

    // a command is taken only when the output register can take its answer
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !o_m_axis_tvalid || i_m_axis_tready)
        else $error("command taken while a result is stalled");

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int DEPTH = 32;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int COMMAND_TARGET = 460;
    localparam int SETTLE_CYCLES = 16;
    localparam int PRINT_LIMIT = 40;

    // mode codes the block takes and ignores
    localparam logic [lsms_pkg::MODE_W-1:0] MODE_SPARE_LO = lsms_pkg::MODE_EMIT + 1'b1;
    localparam logic [lsms_pkg::MODE_W-1:0] MODE_SPARE_HI = {lsms_pkg::MODE_W{1'b1}};

    typedef struct packed {
        logic signed [lsms_pkg::VALUE_W-1:0] element;
        logic [lsms_pkg::STATUS_W-1:0]       status;
        logic                                last;
    } t_result_word;

    typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_SLUGGISH} t_rx_phase;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_s_axis_tvalid = 1'b0;
    logic                          o_s_axis_tready;
    logic [lsms_pkg::VALUE_W-1:0]  i_s_axis_tdata = '0;   // [31:0] value
    logic [lsms_pkg::MODE_W-1:0]   i_s_axis_tuser = '0;   // [2:0] mode
    logic                          o_m_axis_tvalid;
    logic                          i_m_axis_tready = 1'b0;
    logic [lsms_pkg::VALUE_W-1:0]  o_m_axis_tdata;        // [31:0] element
    logic [lsms_pkg::STATUS_W-1:0] o_m_axis_tuser;        // [1:0] status
    logic                          o_m_axis_tlast;

    // predicted list contents, updated on every accepted command word
    logic signed [lsms_pkg::VALUE_W-1:0] list_words [DEPTH];
    int                                  list_count = 0;
    int                                  list_head = 0;
    t_result_word                        expected_words [$];

    // stimulus-side bookkeeping
    int        error_count = 0;
    int        commands_sent = 0;
    int        fill_level = 0;
    int        burst_left = 0;
    bit        sender_steady = 1'b0;
    t_rx_phase rx_phase = RX_OPEN;
    int        rx_phase_left = 0;
    int        rx_stall_left = 0;

    list_store_with_merge_sort #(.DEPTH(DEPTH)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    // append one element word per list entry, or a single empty word
    function automatic void list_as_results();
        t_result_word word;
        int k;
        if (list_count == 0) begin
            word = '{element: '0, status: lsms_pkg::STATUS_EMPTY, last: 1'b1};
            expected_words.push_back(word);
        end else begin
            for (k = 0; k < list_count; k++) begin
                word.element = list_words[IDX_W'((list_head + k) % DEPTH)];
                word.status  = lsms_pkg::STATUS_ELEMENT;
                word.last    = (k == list_count - 1);
                expected_words.push_back(word);
            end
        end
    endfunction

    // advance the list state and queue the words this command causes
    function automatic void predict_command(input logic [lsms_pkg::MODE_W-1:0] mode,
                                            input logic [lsms_pkg::VALUE_W-1:0] value);
        logic signed [lsms_pkg::VALUE_W-1:0] line [DEPTH];
        logic signed [lsms_pkg::VALUE_W-1:0] key;
        t_result_word word;
        int i;
        int j;
        word = '{element: '0, status: lsms_pkg::STATUS_INSERTED, last: 1'b1};
        case (mode)
            lsms_pkg::MODE_PUSH_FRONT, lsms_pkg::MODE_PUSH_BACK: begin
                if (list_count >= DEPTH) begin
                    word.status = lsms_pkg::STATUS_FULL;
                end else if (mode == lsms_pkg::MODE_PUSH_FRONT) begin
                    list_head = (list_head + DEPTH - 1) % DEPTH;
                    list_words[IDX_W'(list_head)] = value;
                    list_count++;
                end else begin
                    list_words[IDX_W'((list_head + list_count) % DEPTH)] = value;
                    list_count++;
                end
                expected_words.push_back(word);
            end
            lsms_pkg::MODE_POP_FRONT: begin
                if (list_count == 0) begin
                    word.status = lsms_pkg::STATUS_EMPTY;
                end else begin
                    word.element = list_words[IDX_W'(list_head)];
                    word.status  = lsms_pkg::STATUS_ELEMENT;
                    list_head = (list_head + 1) % DEPTH;
                    list_count--;
                end
                expected_words.push_back(word);
            end
            lsms_pkg::MODE_SORT: begin
                // stable ascending order, head moves to slot zero
                for (i = 0; i < list_count; i++)
                    line[IDX_W'(i)] = list_words[IDX_W'((list_head + i) % DEPTH)];
                for (i = 1; i < list_count; i++) begin
                    key = line[IDX_W'(i)];
                    j = i;
                    while (j > 0 && line[IDX_W'(j-1)] > key) begin
                        line[IDX_W'(j)] = line[IDX_W'(j-1)];
                        j--;
                    end
                    line[IDX_W'(j)] = key;
                end
                for (i = 0; i < list_count; i++)
                    list_words[IDX_W'(i)] = line[IDX_W'(i)];
                list_head = 0;
                list_as_results();
            end
            lsms_pkg::MODE_EMIT: list_as_results();
            default: ;
        endcase
    endfunction

    // predict on each accepted command, check each accepted result word
    always @(posedge i_clk) begin : monitor
        t_result_word want;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                predict_command(i_s_axis_tuser, i_s_axis_tdata);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("unexpected word element=%0d status=%0d last=%0b",
                        $signed(o_m_axis_tdata), o_m_axis_tuser, o_m_axis_tlast));
                end else begin
                    want = expected_words.pop_front();
                    if (o_m_axis_tdata !== want.element)
                        report_mismatch($sformatf("element %0d, want %0d",
                            $signed(o_m_axis_tdata), want.element));
                    if (o_m_axis_tuser !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                            o_m_axis_tuser, want.status));
                    if (o_m_axis_tlast !== want.last)
                        report_mismatch($sformatf("last %0b, want %0b",
                            o_m_axis_tlast, want.last));
                end
            end
        end
    end

    // result side: open, choppy and sluggish phases of random length
    always @(posedge i_clk) begin
        if (rx_phase_left == 0) begin
            rx_phase_left <= $urandom_range(40, 300);
            rx_phase <= t_rx_phase'($urandom_range(0, 2));
        end else begin
            rx_phase_left <= rx_phase_left - 1;
        end
        if (rx_stall_left != 0) begin
            i_m_axis_tready <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
        end else begin
            i_m_axis_tready <= 1'b1;
            case (rx_phase)
                RX_CHOPPY:   rx_stall_left <= ($urandom_range(0, 2) == 0) ?
                                              $urandom_range(1, 3) : 0;
                RX_SLUGGISH: rx_stall_left <= $urandom_range(2, 7);
                default:     rx_stall_left <= 0;
            endcase
        end
    end

    // drive one command word, hold until taken, then maybe open a gap
    task automatic send_command(input logic [lsms_pkg::MODE_W-1:0] mode,
                                input logic [lsms_pkg::VALUE_W-1:0] value);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= value;
        i_s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        if ((mode == lsms_pkg::MODE_PUSH_FRONT || mode == lsms_pkg::MODE_PUSH_BACK) &&
            fill_level < DEPTH)
            fill_level++;
        else if (mode == lsms_pkg::MODE_POP_FRONT && fill_level > 0)
            fill_level--;
        if (mode <= lsms_pkg::MODE_EMIT)
            commands_sent++;
        if (!sender_steady) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = $urandom_range(1, 6);
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic wait_until_drained();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_words.size() != 0)
            @(posedge i_clk);
    endtask

    // extremes, small values with repeats, and full random words
    function automatic logic [lsms_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2, 3, 4: return $urandom_range(0, 8) - 4;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [lsms_pkg::MODE_W-1:0] pick_push();
        return $urandom_range(0, 1) ? lsms_pkg::MODE_PUSH_BACK : lsms_pkg::MODE_PUSH_FRONT;
    endfunction

    // pop, emit and sort on an empty list, and the spare mode codes
    task automatic test_empty_list();
        send_command(lsms_pkg::MODE_POP_FRONT, $urandom);
        send_command(lsms_pkg::MODE_EMIT, $urandom);
        send_command(lsms_pkg::MODE_SORT, $urandom);
        send_command(MODE_SPARE_LO, $urandom);
        send_command(MODE_SPARE_LO + 1'b1, $urandom);
        send_command(MODE_SPARE_HI, $urandom);
    endtask

    // extreme values at both ends, sort, wrap the head below slot zero
    task automatic test_list_ends();
        send_command(lsms_pkg::MODE_PUSH_FRONT, 32'h8000_0000);
        send_command(lsms_pkg::MODE_PUSH_BACK, 32'h7fff_ffff);
        send_command(lsms_pkg::MODE_PUSH_FRONT, 32'h0000_0000);
        send_command(lsms_pkg::MODE_PUSH_BACK, 32'hffff_ffff);
        send_command(lsms_pkg::MODE_PUSH_FRONT, 32'h0000_0001);
        send_command(lsms_pkg::MODE_PUSH_BACK, 32'h8000_0000);
        send_command(lsms_pkg::MODE_EMIT, $urandom);
        send_command(lsms_pkg::MODE_SORT, $urandom);
        send_command(lsms_pkg::MODE_POP_FRONT, $urandom);
        send_command(lsms_pkg::MODE_POP_FRONT, $urandom);
        send_command(lsms_pkg::MODE_PUSH_FRONT, 32'h0000_0005);
        send_command(lsms_pkg::MODE_EMIT, $urandom);
        repeat (6) send_command(lsms_pkg::MODE_POP_FRONT, $urandom);
    endtask

    // fill to the brim, refuse at both ends, sort and empty again
    task automatic test_fill_and_overflow();
        while (fill_level < DEPTH)
            send_command(pick_push(), pick_value());
        send_command(lsms_pkg::MODE_PUSH_FRONT, $urandom);
        send_command(lsms_pkg::MODE_PUSH_BACK, $urandom);
        send_command(lsms_pkg::MODE_EMIT, $urandom);
        send_command(lsms_pkg::MODE_SORT, $urandom);
        while (fill_level > 0)
            send_command(lsms_pkg::MODE_POP_FRONT, $urandom);
        send_command(lsms_pkg::MODE_POP_FRONT, $urandom);
    endtask

    // random episodes: fills, drains, wrapped sorts, short lists, mixed traffic
    task automatic test_random_traffic();
        int n;
        int pick;
        while (commands_sent < COMMAND_TARGET) begin
            if ($urandom_range(0, 3) == 0)
                sender_steady = ~sender_steady;
            case ($urandom_range(0, 9))
                0, 1: begin
                    while (fill_level < DEPTH)
                        send_command(pick_push(), pick_value());
                    repeat ($urandom_range(1, 2)) send_command(pick_push(), pick_value());
                    send_command($urandom_range(0, 1) ? lsms_pkg::MODE_SORT :
                                 lsms_pkg::MODE_EMIT, $urandom);
                end
                2: begin
                    n = fill_level + $urandom_range(0, 2);
                    repeat (n) send_command(lsms_pkg::MODE_POP_FRONT, $urandom);
                end
                3: begin
                    repeat ($urandom_range(1, 8))
                        send_command(lsms_pkg::MODE_POP_FRONT, $urandom);
                    repeat ($urandom_range(1, 10))
                        send_command(lsms_pkg::MODE_PUSH_FRONT, pick_value());
                    send_command(lsms_pkg::MODE_SORT, $urandom);
                end
                4: begin
                    while (fill_level > 0)
                        send_command(lsms_pkg::MODE_POP_FRONT, $urandom);
                    repeat ($urandom_range(1, 4)) send_command(pick_push(), pick_value());
                    send_command(lsms_pkg::MODE_SORT, $urandom);
                    send_command(lsms_pkg::MODE_EMIT, $urandom);
                end
                default: begin
                    repeat ($urandom_range(8, 24)) begin
                        pick = $urandom_range(0, 19);
                        if (pick <= 7 || pick >= 16)
                            send_command(pick_push(), pick_value());
                        else if (pick <= 12)
                            send_command(lsms_pkg::MODE_POP_FRONT, $urandom);
                        else if (pick == 13)
                            send_command(lsms_pkg::MODE_SORT, $urandom);
                        else if (pick == 14)
                            send_command(lsms_pkg::MODE_EMIT, $urandom);
                        else
                            send_command(lsms_pkg::MODE_W'($urandom_range(MODE_SPARE_LO,
                                                                          MODE_SPARE_HI)),
                                         $urandom);
                    end
                end
            endcase
        end
        sender_steady = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_list();
        test_list_ends();
        test_fill_and_overflow();
        test_random_traffic();
        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TIMEOUT: %0d result words still outstanding", expected_words.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- list_store_with_merge_sort.f -----
rtl/lsms_pkg.sv
rtl/lsms_ram.sv
rtl/lsms_ctrl.sv
rtl/list_store_with_merge_sort.sv
dv/tb.sv
